/* sv/two_level_cache_with_reuse_plru_macros.svh */
// Assertion macros for the cache hierarchy
`ifndef TWO_LEVEL_CACHE_WITH_REUSE_PLRU_MACROS_SVH
`define TWO_LEVEL_CACHE_WITH_REUSE_PLRU_MACROS_SVH
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* sv/tlc_pkg.sv */
// Shared types for the cache hierarchy
package tlc_pkg;
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_WRITE
    } state_t;

    localparam int ADDR_W = 31;
    localparam int CNT_W  = 32;
endpackage

/* sv/tlc_ram.sv */
// Generic single-port RAM with registered read
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* sv/tlc_level.sv */
// One set-associative cache level: set storage, lookup, PLRU touch, fill and drop
module tlc_level #(
    parameter int WAYS = 16,
    parameter int SETS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [tlc_pkg::ADDR_W-1:0] addr,
    input  logic                      wr,
    input  logic                      do_touch,
    input  logic                      do_fill,
    input  logic                      do_drop,
    output logic                      hit
);
    import tlc_pkg::*;

    localparam int SW   = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WW   = $clog2(WAYS);
    localparam int NN   = WAYS - 1;
    localparam int ROWW = WAYS * (ADDR_W + 1) + NN;

    logic [SW-1:0]     set_idx;
    logic [ROWW-1:0]   row_rd;
    logic [ROWW-1:0]   row_wr;
    logic [SETS-1:0]   init_reg;
    logic [SETS-1:0]   init_next;
    logic              row_ok;
    logic [WAYS-1:0]   match;
    logic [WW-1:0]     hit_way;
    logic [WW-1:0]     vic_way;
    logic [NN-1:0]     tree_cur;
    logic [NN-1:0]     tree_new;
    logic [WAYS-1:0]   valid_cur;

    assign set_idx = SW'(addr % ADDR_W'(SETS));

    tlc_ram #(.WIDTH(ROWW), .DEPTH(SETS)) u_ram (
        .clk   (clk),
        .we    (wr),
        .addr  (set_idx),
        .wdata (row_wr),
        .rdata (row_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= '0;
        end
        else
        begin
            init_reg <= init_next;
        end
    end

    always_comb
    begin
        init_next = init_reg;
        if (wr)
        begin
            init_next[set_idx] = 1'b1;
        end
    end

    assign row_ok = init_reg[set_idx];

    always_comb
    begin
        tree_cur = row_ok ? row_rd[NN-1:0] : '0;
        for (int w = 0; w < WAYS; w++)
        begin
            valid_cur[w] = row_ok & row_rd[NN + w*(ADDR_W+1) + ADDR_W];
            match[w] = valid_cur[w]
                & (row_rd[NN + w*(ADDR_W+1) +: ADDR_W] == addr);
        end
        hit_way = '0;
        for (int w = WAYS-1; w >= 0; w--)
        begin
            if (match[w])
            begin
                hit_way = WW'(w);
            end
        end
    end

    assign hit = |match;

    always_comb
    begin
        int n;
        tree_new = tree_cur;
        vic_way  = '0;
        n = 0;
        if (do_fill)
        begin
            for (int l = 0; l < WW; l++)
            begin
                tree_new[n] = ~tree_cur[n];
                vic_way[WW-1-l] = tree_cur[n];
                n = 2*n + 1 + int'(tree_cur[n]);
            end
        end
        else if (do_touch)
        begin
            for (int l = 0; l < WW; l++)
            begin
                tree_new[n] = ~hit_way[WW-1-l];
                n = 2*n + 1 + int'(hit_way[WW-1-l]);
            end
        end
    end

    always_comb
    begin
        row_wr = row_rd;
        row_wr[NN-1:0] = tree_new;
        for (int w = 0; w < WAYS; w++)
        begin
            row_wr[NN + w*(ADDR_W+1) + ADDR_W] = valid_cur[w];
        end
        if (do_drop)
        begin
            row_wr[NN + int'(hit_way)*(ADDR_W+1) + ADDR_W] = 1'b0;
        end
        if (do_fill)
        begin
            row_wr[NN + int'(vic_way)*(ADDR_W+1) +: ADDR_W+1] = {1'b1, addr};
        end
    end
endmodule

/* sv/two_level_cache_with_reuse_plru.sv */
// Top level: three-level PLRU cache hierarchy lookup with hit counters
// channel | direction | handshake         | payload
// request | in        | start / busy      | req_address
// result  | out       | done (one cycle)  | hit flags, three counters
// An address passes through set read, lookup with write back, result strobe, then idle.
// done comes in ST_WRITE, after ST_READ and ST_EVAL; no new word is taken until back in idle.
// The rate is set by the read-modify-write of one row per set in each memory.
// Reset clears the counters and per-set init bits; unwritten sets read empty.
// busy is high from acceptance until done; the receiver cannot stall.
module two_level_cache_with_reuse_plru #(
    parameter int WAYS        = 16,
    parameter int FIRST_SETS  = 8,
    parameter int SECOND_SETS = 16,
    parameter int REUSE_SETS  = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [tlc_pkg::ADDR_W-1:0] req_address,
    output logic                       done,
    output logic                       first_level_hit,
    output logic                       second_level_hit,
    output logic                       reuse_level_hit,
    output logic [tlc_pkg::CNT_W-1:0]  total_lower_hits,
    output logic [tlc_pkg::CNT_W-1:0]  second_hits_count,
    output logic [tlc_pkg::CNT_W-1:0]  reuse_hits_count
);
    import tlc_pkg::*;
    `include "two_level_cache_with_reuse_plru_macros.svh"

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg;
    logic h1, h2, hr;
    logic wr;
    logic h1_reg, h2_reg, hr_reg;
    logic [CNT_W-1:0] tot_reg, sec_reg, reu_reg;

    always_comb
    begin
        case (state_reg)
            ST_IDLE:  state_next = start ? ST_READ : ST_IDLE;
            ST_READ:  state_next = ST_EVAL;
            ST_EVAL:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy = 1'b1;
        wr   = 1'b0;
        done = 1'b0;
        case (state_reg)
            ST_IDLE:  busy = 1'b0;
            ST_EVAL:  wr = 1'b1;
            ST_WRITE: done = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tot_reg   <= '0;
            sec_reg   <= '0;
            reu_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr && !h1 && h2)
            begin
                tot_reg <= tot_reg + 1'b1;
                sec_reg <= sec_reg + 1'b1;
            end
            else if (wr && !h1 && hr)
            begin
                tot_reg <= tot_reg + 1'b1;
                reu_reg <= reu_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            addr_reg <= req_address;
        end
        if (wr)
        begin
            h1_reg <= h1;
            h2_reg <= !h1 && h2;
            hr_reg <= !h1 && !h2 && hr;
        end
    end

    tlc_level #(.WAYS(WAYS), .SETS(FIRST_SETS)) u_l1 (
        .clk(clk), .rst_n(rst_n), .addr(addr_reg),
        .wr(wr), .do_touch(h1), .do_fill(!h1), .do_drop(1'b0), .hit(h1)
    );
    tlc_level #(.WAYS(WAYS), .SETS(SECOND_SETS)) u_l2 (
        .clk(clk), .rst_n(rst_n), .addr(addr_reg),
        .wr(wr && !h1), .do_touch(1'b0), .do_fill(!h2 && !hr),
        .do_drop(h2), .hit(h2)
    );
    tlc_level #(.WAYS(WAYS), .SETS(REUSE_SETS)) u_reuse (
        .clk(clk), .rst_n(rst_n), .addr(addr_reg),
        .wr(wr && !h1 && !h2 && hr || wr && !h1 && h2),
        .do_touch(!h2 && hr), .do_fill(h2), .do_drop(1'b0), .hit(hr)
    );

    assign first_level_hit   = h1_reg;
    assign second_level_hit  = h2_reg;
    assign reuse_level_hit   = hr_reg;
    assign total_lower_hits  = tot_reg;
    assign second_hits_count = sec_reg;
    assign reuse_hits_count  = reu_reg;

    `ASSERT_IMPL(a_one_hit, done, $countones({h1_reg, h2_reg, hr_reg}) <= 1, "multiple hits")
    `ASSERT_IMPL(a_sum, 1'b1, tot_reg == sec_reg + reu_reg, "counter sum broken")
    `ASSERT_NEXT(a_done_after_wr, wr, done, "no result after write back")
endmodule

/* tb/tb_cache_checker.sv */
// Checker: predicts the cache hierarchy outcome per word and compares results
`timescale 1ns / 100ps
module tb_cache_checker #(
    parameter int WAYS        = 16,
    parameter int FIRST_SETS  = 8,
    parameter int SECOND_SETS = 16,
    parameter int REUSE_SETS  = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic [tlc_pkg::ADDR_W-1:0] req_address,
    input  logic                       done,
    input  logic                       first_level_hit,
    input  logic                       second_level_hit,
    input  logic                       reuse_level_hit,
    input  logic [tlc_pkg::CNT_W-1:0]  total_lower_hits,
    input  logic [tlc_pkg::CNT_W-1:0]  second_hits_count,
    input  logic [tlc_pkg::CNT_W-1:0]  reuse_hits_count,
    output int                         fail_count,
    output int                         pending
);
    import tlc_pkg::*;

    localparam int MAXS = 16;

    typedef struct packed {
        logic             h1;
        logic             h2;
        logic             hr;
        logic [CNT_W-1:0] lower;
        logic [CNT_W-1:0] second;
        logic [CNT_W-1:0] reuse;
    } outcome_t;

    typedef struct {
        logic [ADDR_W-1:0] tag   [MAXS][WAYS];
        logic              vld   [MAXS][WAYS];
        logic              node  [MAXS][WAYS];
        int                nsets;
    } cache_m_t;

    cache_m_t l1_m, l2_m, ru_m;
    logic [CNT_W-1:0] lower_tally, second_tally, reuse_tally;
    outcome_t expected_q[$];

    function automatic void clear_cache(ref cache_m_t c, input int n);
        c.nsets = n;
        for (int s = 0; s < MAXS; s++)
            for (int w = 0; w < WAYS; w++)
            begin
                c.vld[s][w]  = 1'b0;
                c.node[s][w] = 1'b0;
                c.tag[s][w]  = '0;
            end
    endfunction

    function automatic int find_way(ref cache_m_t c, input logic [ADDR_W-1:0] a);
        int s;
        s = a % c.nsets;
        for (int w = 0; w < WAYS; w++)
            if (c.vld[s][w] && c.tag[s][w] == a)
                return w;
        return -1;
    endfunction

    function automatic void insert_line(ref cache_m_t c, input logic [ADDR_W-1:0] a);
        int s;
        int n;
        s = a % c.nsets;
        n = 0;
        while (n < WAYS - 1)
        begin
            if (!c.node[s][n])
            begin
                c.node[s][n] = 1'b1;
                n = 2 * n + 1;
            end
            else
            begin
                c.node[s][n] = 1'b0;
                n = 2 * n + 2;
            end
        end
        n -= WAYS - 1;
        c.tag[s][n] = a;
        c.vld[s][n] = 1'b1;
    endfunction

    function automatic void touch_way(ref cache_m_t c, input logic [ADDR_W-1:0] a,
                                      input int way);
        int s;
        int n;
        int p;
        s = a % c.nsets;
        n = WAYS - 1 + way;
        while (n != 0)
        begin
            p = (n - 1) / 2;
            c.node[s][p] = n[0];
            n = p;
        end
    endfunction

    function automatic outcome_t access_hierarchy(input logic [ADDR_W-1:0] a);
        outcome_t o;
        int w;
        int r;
        o = '0;
        w = find_way(l1_m, a);
        if (w >= 0)
        begin
            o.h1 = 1'b1;
            touch_way(l1_m, a, w);
        end
        else
        begin
            w = find_way(l2_m, a);
            if (w >= 0)
            begin
                o.h2 = 1'b1;
                l2_m.vld[a % l2_m.nsets][w] = 1'b0;
                insert_line(ru_m, a);
                lower_tally++;
                second_tally++;
            end
            else
            begin
                r = find_way(ru_m, a);
                if (r < 0)
                    insert_line(l2_m, a);
                else
                begin
                    o.hr = 1'b1;
                    touch_way(ru_m, a, r);
                    lower_tally++;
                    reuse_tally++;
                end
            end
            insert_line(l1_m, a);
        end
        o.lower  = lower_tally;
        o.second = second_tally;
        o.reuse  = reuse_tally;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count   = 0;
        lower_tally  = '0;
        second_tally = '0;
        reuse_tally  = '0;
        clear_cache(l1_m, FIRST_SETS);
        clear_cache(l2_m, SECOND_SETS);
        clear_cache(ru_m, REUSE_SETS);
    end

    assign pending = expected_q.size();

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t unexpected result word", $realtime);
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (first_level_hit !== e.h1)
                        report_mismatch("first_level_hit", CNT_W'(first_level_hit),
                                        CNT_W'(e.h1));
                    if (second_level_hit !== e.h2)
                        report_mismatch("second_level_hit", CNT_W'(second_level_hit),
                                        CNT_W'(e.h2));
                    if (reuse_level_hit !== e.hr)
                        report_mismatch("reuse_level_hit", CNT_W'(reuse_level_hit),
                                        CNT_W'(e.hr));
                    if (total_lower_hits !== e.lower)
                        report_mismatch("total_lower_hits", total_lower_hits, e.lower);
                    if (second_hits_count !== e.second)
                        report_mismatch("second_hits_count", second_hits_count, e.second);
                    if (reuse_hits_count !== e.reuse)
                        report_mismatch("reuse_hits_count", reuse_hits_count, e.reuse);
                end
            end
            if (start && !busy)
                expected_q.push_back(access_hierarchy(req_address));
        end
    end
endmodule

/* tb/tb_top.sv */
// Testbench top: drives address words into the cache hierarchy, gives the verdict
`timescale 1ns / 100ps
module tb_top;
    import tlc_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [ADDR_W-1:0] req_address;
    logic              done;
    logic              first_level_hit, second_level_hit, reuse_level_hit;
    logic [CNT_W-1:0]  total_lower_hits, second_hits_count, reuse_hits_count;
    int                fail_count;
    int                pending;
    int                cycles;
    int                idle_pct;

    two_level_cache_with_reuse_plru u_top (.*);

    tb_cache_checker u_chk (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic send_word(input logic [ADDR_W-1:0] a);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        req_address <= a;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Mostly a small pool of addresses so L1/L2/reuse all see hits and evictions
    function automatic logic [ADDR_W-1:0] pick_address(input int pool);
        int k;
        k = $urandom_range(99);
        if (k < 8)
            return ADDR_W'($urandom);
        else if (k < 12)
            return {1'($urandom_range(1)), {(ADDR_W - 1){1'b1}}}
                   - ADDR_W'($urandom_range(40));
        else
            return ADDR_W'($urandom_range(pool - 1) * 3 + 5);
    endfunction

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req_address = '0;
        idle_pct    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word('0);
        send_word('0);
        send_word({ADDR_W{1'b1}});
        send_word({ADDR_W{1'b1}});
        send_word(31'h5555_5555);
        send_word(31'h2AAA_AAAA);
        // fill one set of L1 past capacity so early lines are evicted; each miss also fills L2
        for (int i = 0; i < 18; i++)
            send_word(ADDR_W'(i * 8 + 16));

        for (int i = 0; i < 1550; i++)
        begin
            if (i < 500)
                idle_pct = 22;
            else if (i < 1000)
                idle_pct = 50;
            else
                idle_pct = 0;
            send_word(pick_address(i % 300 < 150 ? 60 : 400));
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
